// ===== sv/pcs_pkg.sv =====
`timescale 1ns / 1ps
// pcs_pkg: shared widths, register indexes, micro-op codes and the control store
// of the PID controller step sequencer. No dependencies.
package pcs_pkg;

    localparam int DataW     = 32;
    localparam int LimW      = 31;
    localparam int InTdataW  = 64;
    localparam int OutTdataW = 32;
    localparam int CfgIdxW   = 3;
    localparam int DivCntW   = 6;
    localparam int StepW     = 4;

    localparam logic [DivCntW-1:0] DivLast = 6'd63;
    localparam logic [48:0] DerivCap = 49'h1_0000_0000_0000;

    localparam logic [CfgIdxW-1:0] RegGainProp  = 3'd0;
    localparam logic [CfgIdxW-1:0] RegGainInteg = 3'd1;
    localparam logic [CfgIdxW-1:0] RegGainDeriv = 3'd2;
    localparam logic [CfgIdxW-1:0] RegIntegLim  = 3'd3;
    localparam logic [CfgIdxW-1:0] RegDriveLim  = 3'd4;

    typedef logic [StepW-1:0] step_t;

    localparam step_t StIdle    = 4'd0;
    localparam step_t StDtChk   = 4'd1;
    localparam step_t StMulP    = 4'd2;
    localparam step_t StTakeP   = 4'd3;
    localparam step_t StAcc     = 4'd4;
    localparam step_t StMulI    = 4'd5;
    localparam step_t StTakeI   = 4'd6;
    localparam step_t StDivInit = 4'd7;
    localparam step_t StDivLoop = 4'd8;
    localparam step_t StSum     = 4'd9;
    localparam step_t StEmit    = 4'd10;
    localparam step_t StRet     = 4'd11;
    localparam step_t StZero    = 4'd12;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_P,
        MUL_EDT,
        MUL_I,
        MUL_D
    } mul_sel_t;

    typedef enum logic [3:0] {
        ALU_NOP,
        ALU_LOAD,
        ALU_TAKE_P,
        ALU_ACC,
        ALU_TAKE_I,
        ALU_DIV_INIT,
        ALU_DIV_STEP,
        ALU_SUM,
        ALU_EMIT,
        ALU_ZERO
    } alu_op_t;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_NO_IN,
        COND_DT_ZERO,
        COND_FIRST,
        COND_DIV_BUSY,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        mul_sel_t mul;
        alu_op_t  alu;
        cond_t    cond;
        step_t    target;
    } ucode_t;

    typedef struct packed {
        logic in_fire;
        logic dt_zero;
        logic first;
        logic div_busy;
        logic out_busy;
    } status_t;

    function automatic ucode_t ucode_rom(input step_t pc);
        ucode_t w;
        unique case (pc)
            StIdle:    w = '{MUL_NONE, ALU_LOAD,     COND_NO_IN,    StIdle};
            StDtChk:   w = '{MUL_NONE, ALU_NOP,      COND_DT_ZERO,  StZero};
            StMulP:    w = '{MUL_P,    ALU_NOP,      COND_NEXT,     StIdle};
            StTakeP:   w = '{MUL_EDT,  ALU_TAKE_P,   COND_NEXT,     StIdle};
            StAcc:     w = '{MUL_NONE, ALU_ACC,      COND_NEXT,     StIdle};
            StMulI:    w = '{MUL_I,    ALU_NOP,      COND_NEXT,     StIdle};
            StTakeI:   w = '{MUL_D,    ALU_TAKE_I,   COND_NEXT,     StIdle};
            StDivInit: w = '{MUL_NONE, ALU_DIV_INIT, COND_FIRST,    StSum};
            StDivLoop: w = '{MUL_NONE, ALU_DIV_STEP, COND_DIV_BUSY, StDivLoop};
            StSum:     w = '{MUL_NONE, ALU_SUM,      COND_NEXT,     StIdle};
            StEmit:    w = '{MUL_NONE, ALU_EMIT,     COND_OUT_BUSY, StEmit};
            StRet:     w = '{MUL_NONE, ALU_NOP,      COND_ALWAYS,   StIdle};
            StZero:    w = '{MUL_NONE, ALU_ZERO,     COND_ALWAYS,   StEmit};
            default:   w = '{MUL_NONE, ALU_NOP,      COND_ALWAYS,   StIdle};
        endcase
        return w;
    endfunction

endpackage

// ===== sv/pid_controller_step.sv =====
`timescale 1ns / 1ps
// pid_controller_step: top level, sequencer plus datapath.
// Depends on pcs_pkg, pcs_seq, pcs_dp.
//
// Usage:
//   Input stream s_*: one transfer per control sample. s_tready is high only
//   while the sequencer sits at its idle step.
//   Output stream m_*: one result per input, held in an output register until
//   taken; a stalled receiver holds the result and the sequencer waits at its
//   emit step only if the next result is ready before the previous one left.
//   Configuration: cfg_we/cfg_index/cfg_data, one register per write, only
//   while the block is idle.
// Timing: m_tvalid follows an input transfer soonest for a zero time step,
//   later for the first sample after reset or restart, latest otherwise, when
//   the derivative term passes through the one-bit-per-cycle restoring divider
//   that the control store loops over for its 64-bit quotient. A new input is
//   taken only once the sequencer is back at its idle step after the emit step.
// Reset: gains cleared, limits at maximum, integral and previous error zero,
//   first-sample flag set; the sequencer rests at its idle step, so s_tready
//   is high during reset and stays high until the first transfer.
module pid_controller_step (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [pcs_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [pcs_pkg::DataW-1:0]      cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [pcs_pkg::InTdataW-1:0]   s_tdata,   // [31:0] error_sample, [63:32] time_step
    input  logic                           s_tuser,   // [0] restart
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pcs_pkg::OutTdataW-1:0]  m_tdata,   // [31:0] drive
    output logic                           m_tuser    // [0] drive_clamped
);
    import pcs_pkg::*;

    ucode_t  uw;
    status_t st;
    logic    idle;

    assign s_tready = idle;

    pcs_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .uw    (uw),
        .idle  (idle)
    );

    pcs_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .uw        (uw),
        .st        (st)
    );

endmodule

// ===== sv/pcs_seq.sv =====
`timescale 1ns / 1ps
// pcs_seq: step counter and control store lookup with conditional jumps.
// Depends on pcs_pkg.
module pcs_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  pcs_pkg::status_t st,
    output pcs_pkg::ucode_t  uw,
    output logic             idle
);
    import pcs_pkg::*;

    step_t pc_reg;
    step_t pc_next;
    logic  jump;

    assign uw   = ucode_rom(pc_reg);
    assign idle = (pc_reg == StIdle);

    always_comb
    begin
        unique case (uw.cond)
            COND_NEXT:     jump = 1'b0;
            COND_ALWAYS:   jump = 1'b1;
            COND_NO_IN:    jump = !st.in_fire;
            COND_DT_ZERO:  jump = st.dt_zero;
            COND_FIRST:    jump = st.first;
            COND_DIV_BUSY: jump = st.div_busy;
            COND_OUT_BUSY: jump = st.out_busy;
            default:       jump = 1'b0;
        endcase
        pc_next = jump ? uw.target : pc_reg + step_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= StIdle;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== sv/pcs_dp.sv =====
`timescale 1ns / 1ps
// pcs_dp: datapath - config registers, controller state, shared multiplier,
// restoring divider, clamps and the output register. Depends on pcs_pkg.
module pcs_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pcs_pkg::CfgIdxW-1:0]       cfg_index,
    input  logic [pcs_pkg::DataW-1:0]         cfg_data,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [pcs_pkg::InTdataW-1:0]      s_tdata,
    input  logic                              s_tuser,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [pcs_pkg::OutTdataW-1:0]     m_tdata,
    output logic                              m_tuser,
    input  pcs_pkg::ucode_t                   uw,
    output pcs_pkg::status_t                  st
);
    import pcs_pkg::*;

    logic [DataW-1:0] gain_prop_reg;
    logic [DataW-1:0] gain_integ_reg;
    logic [DataW-1:0] gain_deriv_reg;
    logic [LimW-1:0]  integ_limit_reg;
    logic [LimW-1:0]  drive_limit_reg;

    logic [DataW-1:0] integ_acc_reg;
    logic [DataW-1:0] integ_acc_next;
    logic [DataW-1:0] last_error_reg;
    logic             first_pending_reg;
    logic             m_tvalid_reg;
    logic             m_tvalid_next;
    logic [DivCntW-1:0] div_cnt_reg;

    logic [DataW-1:0] err_reg;
    logic [DataW-1:0] dt_reg;
    logic [63:0]      prod_reg;
    logic [47:0]      p_reg;
    logic signed [49:0] sum_reg;
    logic signed [49:0] sum_next;
    logic [DataW-1:0] rem_reg;
    logic [DataW-1:0] rem_next;
    logic [63:0]      quo_reg;
    logic [63:0]      quo_next;
    logic             neg_reg;
    logic [DataW-1:0] res_drive_reg;
    logic [DataW-1:0] res_drive_next;
    logic             res_clamped_reg;
    logic             res_clamped_next;
    logic [DataW-1:0] out_drive_reg;
    logic             out_clamped_reg;

    logic               in_fire;
    logic               out_free;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_full;
    logic signed [32:0] diff;
    logic signed [48:0] acc_sum;
    logic signed [48:0] acc_lim;
    logic signed [48:0] acc_clamp;
    logic [63:0]        div_mag;
    logic [32:0]        rem_sh;
    logic               div_ge;
    logic [48:0]        q_cap;
    logic signed [49:0] d_mag;
    logic signed [49:0] d_val;
    logic signed [49:0] total;
    logic signed [49:0] drv_lim;
    logic signed [49:0] drv_clamp;

    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign st.in_fire  = in_fire;
    assign st.dt_zero  = (dt_reg == '0);
    assign st.first    = first_pending_reg;
    assign st.div_busy = (div_cnt_reg != DivLast);
    assign st.out_busy = !out_free;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_drive_reg;
    assign m_tuser  = out_clamped_reg;

    assign diff = $signed({err_reg[31], err_reg}) - $signed({last_error_reg[31], last_error_reg});

    // shared multiplier operand select
    always_comb
    begin
        unique case (uw.mul)
            MUL_P:
            begin
                mul_a = $signed({gain_prop_reg[31], gain_prop_reg});
                mul_b = $signed({err_reg[31], err_reg});
            end
            MUL_EDT:
            begin
                mul_a = $signed({err_reg[31], err_reg});
                mul_b = $signed({1'b0, dt_reg});
            end
            MUL_I:
            begin
                mul_a = $signed({gain_integ_reg[31], gain_integ_reg});
                mul_b = $signed({integ_acc_reg[31], integ_acc_reg});
            end
            MUL_D:
            begin
                mul_a = $signed({gain_deriv_reg[31], gain_deriv_reg});
                mul_b = diff;
            end
            MUL_NONE:
            begin
                mul_a = '0;
                mul_b = '0;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_full = mul_a * mul_b;
    end

    // integral accumulate and clamp
    always_comb
    begin
        acc_sum = $signed({{17{integ_acc_reg[31]}}, integ_acc_reg})
                + $signed({prod_reg[63], prod_reg[63:16]});
        acc_lim = $signed({18'd0, integ_limit_reg});
        if (acc_sum > acc_lim)
            acc_clamp = acc_lim;
        else if (acc_sum < -acc_lim)
            acc_clamp = -acc_lim;
        else
            acc_clamp = acc_sum;
        integ_acc_next = acc_clamp[31:0];
    end

    assign sum_next = $signed({{2{p_reg[47]}}, p_reg})
                    + $signed({{2{prod_reg[63]}}, prod_reg[63:16]});

    // one restoring divide step per cycle
    always_comb
    begin
        div_mag  = prod_reg[63] ? (64'd0 - prod_reg) : prod_reg;
        rem_sh   = {rem_reg, quo_reg[63]};
        div_ge   = (rem_sh >= {1'b0, dt_reg});
        rem_next = div_ge ? 32'(rem_sh - {1'b0, dt_reg}) : rem_sh[31:0];
        quo_next = {quo_reg[62:0], div_ge};
    end

    // derivative cap, final sum and drive clamp
    always_comb
    begin
        q_cap = (quo_reg > 64'(DerivCap)) ? DerivCap : quo_reg[48:0];
        d_mag = $signed({1'b0, q_cap});
        if (first_pending_reg)
            d_val = '0;
        else if (neg_reg)
            d_val = -d_mag;
        else
            d_val = d_mag;
        total   = sum_reg + d_val;
        drv_lim = $signed({19'd0, drive_limit_reg});
        res_clamped_next = 1'b1;
        if (total > drv_lim)
            drv_clamp = drv_lim;
        else if (total < -drv_lim)
            drv_clamp = -drv_lim;
        else
        begin
            drv_clamp        = total;
            res_clamped_next = 1'b0;
        end
        res_drive_next = drv_clamp[31:0];
    end

    always_comb
    begin
        if (uw.alu == ALU_EMIT && out_free)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
        else
            m_tvalid_next = m_tvalid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_prop_reg     <= '0;
            gain_integ_reg    <= '0;
            gain_deriv_reg    <= '0;
            integ_limit_reg   <= '1;
            drive_limit_reg   <= '1;
            integ_acc_reg     <= '0;
            last_error_reg    <= '0;
            first_pending_reg <= 1'b1;
            m_tvalid_reg      <= 1'b0;
            div_cnt_reg       <= '0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    RegGainProp:  gain_prop_reg   <= cfg_data;
                    RegGainInteg: gain_integ_reg  <= cfg_data;
                    RegGainDeriv: gain_deriv_reg  <= cfg_data;
                    RegIntegLim:  integ_limit_reg <= cfg_data[LimW-1:0];
                    RegDriveLim:  drive_limit_reg <= cfg_data[LimW-1:0];
                    default:      ;
                endcase
            end
            if (uw.alu == ALU_LOAD && in_fire && s_tuser)
            begin
                integ_acc_reg     <= '0;
                last_error_reg    <= '0;
                first_pending_reg <= 1'b1;
            end
            if (uw.alu == ALU_ACC)
                integ_acc_reg <= integ_acc_next;
            if (uw.alu == ALU_SUM)
            begin
                last_error_reg    <= err_reg;
                first_pending_reg <= 1'b0;
            end
            if (uw.alu == ALU_DIV_INIT)
                div_cnt_reg <= '0;
            else if (uw.alu == ALU_DIV_STEP)
                div_cnt_reg <= div_cnt_reg + DivCntW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (uw.mul != MUL_NONE)
            prod_reg <= mul_full[63:0];
        unique case (uw.alu)
            ALU_LOAD:
            begin
                if (in_fire)
                begin
                    err_reg <= s_tdata[31:0];
                    dt_reg  <= s_tdata[63:32];
                end
            end
            ALU_TAKE_P:   p_reg   <= prod_reg[63:16];
            ALU_TAKE_I:   sum_reg <= sum_next;
            ALU_DIV_INIT:
            begin
                neg_reg <= prod_reg[63];
                quo_reg <= div_mag;
                rem_reg <= '0;
            end
            ALU_DIV_STEP:
            begin
                quo_reg <= quo_next;
                rem_reg <= rem_next;
            end
            ALU_SUM:
            begin
                res_drive_reg   <= res_drive_next;
                res_clamped_reg <= res_clamped_next;
            end
            ALU_ZERO:
            begin
                res_drive_reg   <= '0;
                res_clamped_reg <= 1'b0;
            end
            ALU_EMIT:
            begin
                if (out_free)
                begin
                    out_drive_reg   <= res_drive_reg;
                    out_clamped_reg <= res_clamped_reg;
                end
            end
            ALU_NOP, ALU_ACC: ;
            default: ;
        endcase
    end

endmodule

// ===== sv/pcs_chk.sv =====
`timescale 1ns / 1ps
// pcs_chk: port-level checks of the PID controller step, bound to the top.
// Depends on pcs_pkg and pid_controller_step.
module pcs_chk (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [pcs_pkg::InTdataW-1:0]   s_tdata,
    input logic                           s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [pcs_pkg::OutTdataW-1:0]  m_tdata,
    input logic                           m_tuser
);
    import pcs_pkg::*;

    logic in_xfer;

    assign in_xfer = s_tvalid && s_tready && (s_tdata == s_tdata) && (s_tuser == s_tuser);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_rst_quiet: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("result valid during reset");

    // one item at a time
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !s_tready)
        else $error("input ready right after a transfer");

    a_no_instant_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !$rose(m_tvalid))
        else $error("result appeared one cycle after input transfer");

endmodule

bind pid_controller_step pcs_chk u_pcs_chk (.*);

// ===== sim/pid_controller_step_tb.sv =====
`timescale 1ns / 1ps
// pid_controller_step_tb: self-checking testbench for the PID controller step block.
// Streams control samples into pid_controller_step, predicts each drive value in a local model
// and checks every result transfer. Depends on pcs_pkg and pid_controller_step.
module pid_controller_step_tb;
    import pcs_pkg::*;

    localparam logic [CfgIdxW-1:0] RegSpareLo = 3'd5;
    localparam logic [CfgIdxW-1:0] RegSpareHi = 3'd7;
    localparam int  StallLimit = 4000;
    localparam int  LongHold   = 300;
    localparam int  DrainWait  = 80;
    localparam logic [63:0] DerivCeil = 64'h0001_0000_0000_0000;

    typedef struct packed {
        logic [31:0] drive;
        logic        clamped;
    } drive_res_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CfgIdxW-1:0]    cfg_index;
    logic [DataW-1:0]      cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [InTdataW-1:0]   s_tdata;   // [31:0] error_sample, [63:32] time_step
    logic                  s_tuser;   // [0] restart
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OutTdataW-1:0]  m_tdata;   // [31:0] drive
    logic                  m_tuser;   // [0] drive_clamped

    // model copy of the registers and loop state
    logic signed [31:0] kp_set, ki_set, kd_set;
    logic [30:0]        integ_lim_set, drive_lim_set;
    logic signed [31:0] integ_sum, prev_err;
    logic               first_due;

    drive_res_t pending_drive_q[$];
    int         fail_count;
    int         quiet_cycles;
    bit         throttle;
    bit         hold_tog;
    bit         hold_seen;
    int         rx_wait;

    pid_controller_step DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #10 clk = ~clk;

    function automatic drive_res_t compute_drive(input logic signed [31:0] err,
                                                 input logic [31:0] dt,
                                                 input logic restart);
        drive_res_t r;
        longint e, dtl, pterm, iterm, dterm, acc, sum, prod, ilim, dlim;
        logic [63:0] mag, quo;
        r.drive   = '0;
        r.clamped = 1'b0;
        if (restart)
        begin
            integ_sum = '0;
            prev_err  = '0;
            first_due = 1'b1;
        end
        if (dt == 32'd0)
            return r;
        e     = err;
        dtl   = longint'({32'd0, dt});
        ilim  = longint'({33'd0, integ_lim_set});
        dlim  = longint'({33'd0, drive_lim_set});
        pterm = (longint'(kp_set) * e) >>> 16;
        acc   = longint'(integ_sum) + ((e * dtl) >>> 16);
        if (acc > ilim)
            acc = ilim;
        else if (acc < -ilim)
            acc = -ilim;
        integ_sum = 32'(acc);
        iterm = (longint'(ki_set) * acc) >>> 16;
        dterm = 0;
        if (!first_due)
        begin
            prod = longint'(kd_set) * (e - longint'(prev_err));
            mag  = (prod < 0) ? 64'(-prod) : 64'(prod);
            quo  = mag / {32'd0, dt};
            if (quo > DerivCeil)
                quo = DerivCeil;
            dterm = (prod < 0) ? -longint'(quo) : longint'(quo);
        end
        first_due = 1'b0;
        prev_err  = err;
        sum = pterm + iterm + dterm;
        if (sum > dlim)
        begin
            sum = dlim;
            r.clamped = 1'b1;
        end
        else if (sum < -dlim)
        begin
            sum = -dlim;
            r.clamped = 1'b1;
        end
        r.drive = 32'(sum);
        return r;
    endfunction

    // predict on input transfers, check on output transfers
    always @(posedge clk)
    begin
        drive_res_t want;
        if (rst_n && s_tvalid && s_tready)
            pending_drive_q.push_back(compute_drive(s_tdata[31:0], s_tdata[63:32], s_tuser));
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_drive_q.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, got drive %h clamped %b",
                         $time, m_tdata, m_tuser);
                fail_count++;
            end
            else
            begin
                want = pending_drive_q.pop_front();
                if (m_tdata !== want.drive)
                begin
                    $display("%0t ns: drive mismatch, expected %h, got %h",
                             $time, want.drive, m_tdata);
                    fail_count++;
                end
                if (m_tuser !== want.clamped)
                begin
                    $display("%0t ns: drive_clamped mismatch, expected %b, got %b",
                             $time, want.clamped, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(20, 120);
        return $urandom_range(0, 3);
    endfunction

    // receiver: random stalls, plus a long hold on request
    always @(posedge clk)
    begin
        if (hold_tog != hold_seen)
        begin
            hold_seen = hold_tog;
            rx_wait   = LongHold;
        end
        if (rx_wait > 0)
        begin
            m_tready <= 1'b0;
            rx_wait--;
        end
        else if (throttle && m_tready && $urandom_range(0, 3) == 0)
        begin
            m_tready <= 1'b0;
            rx_wait = pick_gap();
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit)
        begin
            $display("pid_controller_step verification failed");
            $finish;
        end
    end

    task automatic send_sample(input logic [31:0] err, input logic [31:0] dt,
                               input logic restart);
        int gap;
        gap = throttle ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {dt, err};
        s_tuser  <= restart;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // advance the clock before checking the queue, so a transfer taken on the current edge is already queued
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_drive_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            RegGainProp:  kp_set = val;
            RegGainInteg: ki_set = val;
            RegGainDeriv: kd_set = val;
            RegIntegLim:  integ_lim_set = val[30:0];
            RegDriveLim:  drive_lim_set = val[30:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_gains(input logic [31:0] kp, input logic [31:0] ki,
                             input logic [31:0] kd, input logic [31:0] ilim,
                             input logic [31:0] dlim);
        drain_results();
        write_reg(RegGainProp, kp);
        write_reg(RegGainInteg, ki);
        write_reg(RegGainDeriv, kd);
        write_reg(RegIntegLim, ilim);
        write_reg(RegDriveLim, dlim);
    endtask

    function automatic logic [31:0] rand_gain();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        endcase
    endfunction

    function automatic logic [31:0] rand_limit();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'h7FFF_FFFF;
            2: return $urandom & 32'h7FFF_FFFF;
            default: return $urandom_range(32'h0001_0000, 32'h0400_0000);
        endcase
    endfunction

    function automatic logic [31:0] rand_error();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return $urandom;
            default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    function automatic logic [31:0] rand_step();
        case ($urandom_range(0, 15))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'hFFFF_FFFF;
            3, 4, 5: return $urandom;
            default: return $urandom_range(1, 32'h0002_0000);
        endcase
    endfunction

    // gains at reset are zero, so drive stays at zero
    task automatic test_reset_defaults();
        send_sample(32'h0001_0000, 32'h0001_0000, 1'b0);
        send_sample(32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    endtask

    task automatic test_special_cases();
        set_gains(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h0010_0000, 32'h0100_0000);
        send_sample(32'h0002_0000, 32'h0001_0000, 1'b1);
        send_sample(32'hFFFF_0000, 32'h0000_8000, 1'b0);
        send_sample(32'h1234_5678, 32'd0,         1'b0);   // zero step keeps state
        send_sample(32'h0003_0000, 32'h0000_4000, 1'b0);
        send_sample(32'h0005_0000, 32'd0,         1'b1);   // zero step, restart still clears
        send_sample(32'h0005_0000, 32'h0001_0000, 1'b0);
        send_sample(32'h0004_0000, 32'd1,         1'b0);   // tiny step, drive clamps
        send_sample(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);   // integral saturates high
        send_sample(32'h8000_0000, 32'hFFFF_FFFF, 1'b0);   // and low
        send_sample(32'd0,         32'h0001_0000, 1'b1);
        drain_results();
        // writes beyond the last register are ignored
        write_reg(RegSpareLo, 32'hFFFF_FFFF);
        write_reg(RegSpareHi, 32'h8000_0001);
        send_sample(32'h0001_0000, 32'h0001_0000, 1'b0);
    endtask

    task automatic test_extremes();
        set_gains(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_sample(32'h8000_0000, 32'd1,         1'b1);
        send_sample(32'h7FFF_FFFF, 32'd1,         1'b0);   // derivative hits its ceiling
        send_sample(32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        send_sample(32'd0,         32'h0001_0000, 1'b0);
        set_gains(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0);
        send_sample(32'h7FFF_FFFF, 32'd1,         1'b0);
        send_sample(32'h8000_0000, 32'd1,         1'b0);
        send_sample(32'd0,         32'h0001_0000, 1'b0);
    endtask

    // receiver holds off while samples keep coming, so the input stalls
    task automatic test_backpressure();
        set_gains(32'h0001_0000, 32'h0000_4000, 32'h0000_2000, 32'h0100_0000, 32'h7FFF_FFFF);
        throttle = 1'b0;
        hold_tog = ~hold_tog;
        for (int k = 0; k < 10; k++)
            send_sample(rand_error(), rand_step(), 1'b0);
        throttle = 1'b1;
    endtask

    task automatic test_random_phases(input int phases, input int per_phase);
        for (int ph = 0; ph < phases; ph++)
        begin
            if (ph == 0)
                set_gains(32'h0000_C000, 32'h0000_2000, 32'h0000_1000,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF);
            else
                set_gains(rand_gain(), rand_gain(), rand_gain(), rand_limit(), rand_limit());
            for (int k = 0; k < per_phase; k++)
                send_sample(rand_error(), rand_step(), $urandom_range(0, 19) == 0);
        end
    endtask

    task automatic test_no_idle(input int count);
        set_gains(rand_gain(), rand_gain(), rand_gain(), rand_limit(), 32'h0800_0000);
        throttle = 1'b0;
        for (int k = 0; k < count; k++)
            send_sample(rand_error(), rand_step(), $urandom_range(0, 19) == 0);
        drain_results();
        throttle = 1'b1;
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        m_tready      = 1'b0;
        kp_set        = '0;
        ki_set        = '0;
        kd_set        = '0;
        integ_lim_set = 31'h7FFF_FFFF;
        drive_lim_set = 31'h7FFF_FFFF;
        integ_sum     = '0;
        prev_err      = '0;
        first_due     = 1'b1;
        fail_count    = 0;
        quiet_cycles  = 0;
        throttle      = 1'b1;
        hold_tog      = 1'b0;
        hold_seen     = 1'b0;
        rx_wait       = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_special_cases();
        test_extremes();
        test_backpressure();
        test_random_phases(5, 80);
        test_no_idle(60);

        drain_results();
        repeat (DrainWait) @(posedge clk);
        if (pending_drive_q.size() != 0)
        begin
            $display("%0t ns: results outstanding, expected 0, got %0d",
                     $time, pending_drive_q.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("pid_controller_step verification clean");
        else
            $display("pid_controller_step verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/pcs_pkg.sv
sv/pcs_seq.sv
sv/pcs_dp.sv
sv/pid_controller_step.sv
sv/pcs_chk.sv
sim/pid_controller_step_tb.sv
